// ----- sv/twsc_pkg.sv -----
`timescale 1ns / 1ps
package twsc_pkg;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_DIM      = 4096;
  localparam int POS_W        = 12;
  localparam int DIM_W        = 13;
  localparam int STR_W        = 8;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CRD_W        = FRAC_BITS + 2;
  localparam int XW           = CRD_W + 1;
  localparam int SQ_W         = 2 * CRD_W;
  localparam int RT_W         = CRD_W;
  localparam int CW           = CRD_W + 4;
  localparam int TW           = 34;
  localparam int TU_W         = 37;
  localparam int CORDIC_ITERS = 28;

  localparam logic [DIM_W-1:0] ROWS_RST     = DIM_W'(512);
  localparam logic [DIM_W-1:0] COLS_RST     = DIM_W'(512);
  localparam logic [STR_W-1:0] STRENGTH_RST = STR_W'(80);

  localparam logic signed [TW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [TW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [TW-1:0] ANG_TWO_PI  = 34'sd6746518852;
  localparam logic signed [31:0]   CORDIC_KINV = 32'sd652032874;

  localparam logic [29:0] ATAN_Q30 [CORDIC_ITERS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS     = 2'd0,
    REG_COLS     = 2'd1,
    REG_STRENGTH = 2'd2
  } cfg_reg_t;
endpackage

// ----- sv/twsc_if.sv -----
`timescale 1ns / 1ps
interface twsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [twsc_pkg::POS_W-1:0]  out_row;
  logic [twsc_pkg::POS_W-1:0]  out_col;
  modport source (output valid, output out_row, output out_col, input ready);
  modport sink (input valid, input out_row, input out_col, output ready);
endinterface

interface twsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [twsc_pkg::POS_W-1:0]  src_row;
  logic [twsc_pkg::POS_W-1:0]  src_col;
  modport source (output valid, output src_row, output src_col, input ready);
  modport sink (input valid, input src_row, input src_col, output ready);
endinterface

// ----- sv/twsc_norm.sv -----
`timescale 1ns / 1ps
module twsc_norm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               vld_i,
  input  logic [twsc_pkg::POS_W-1:0]         row,
  input  logic [twsc_pkg::POS_W-1:0]         col,
  input  logic [twsc_pkg::DIM_W-1:0]         rows,
  input  logic [twsc_pkg::DIM_W-1:0]         cols,
  output logic                               vld_o,
  output logic signed [twsc_pkg::CRD_W-1:0]  x,
  output logic signed [twsc_pkg::CRD_W-1:0]  y
);
  import twsc_pkg::*;

  localparam int NB = POS_W + FRAC_BITS;
  localparam int RW = DIM_W - 1;
  localparam logic [NB-1:0] SAT_Q =
    NB'((1 << (FRAC_BITS + 1)) + (1 << (FRAC_BITS - 1)) - 1);
  localparam logic signed [CRD_W-1:0] CRD_MAX = CRD_W'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [CRD_W-1:0] HALF = CRD_W'(1 << (FRAC_BITS - 1));

  logic [NB:0]                vld;
  logic [POS_W-1:0]           pos [2][POS_W];
  logic [RW-1:0]              rem [2][NB+1];
  logic [NB-1:0]              quo [2][NB+1];
  logic [DIM_W-1:0]           dim [2];
  logic signed [CRD_W-1:0]    crd [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NB-1:0], vld_i};
    end
  end

  assign pos[0][0] = col;
  assign pos[1][0] = row;
  assign dim[0]    = cols;
  assign dim[1]    = rows;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign rem[l][0] = '0;
    assign quo[l][0] = '0;

    for (genvar s = 0; s < NB; s++) begin : g_stage
      localparam int BI = NB - 1 - s;
      logic          nb;
      logic [RW:0]   sh;
      logic          ge;

      if (BI >= FRAC_BITS) begin : g_bit
        assign nb = pos[l][s][BI-FRAC_BITS];
      end else begin : g_zero
        assign nb = 1'b0;
      end

      assign sh = {rem[l][s], nb};
      assign ge = sh >= dim[l];

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][s+1] <= ge ? RW'(sh - dim[l]) : sh[RW-1:0];
          quo[l][s+1] <= {quo[l][s][NB-2:0], ge};
        end
      end

      if (s < POS_W - 1) begin : g_pos
        always_ff @(posedge clk) begin
          if (en) begin
            pos[l][s+1] <= pos[l][s];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        crd[l] <= (quo[l][NB] > SAT_Q) ? CRD_MAX : CRD_W'(quo[l][NB]) - HALF;
      end
    end
  end

  assign vld_o = vld[NB];
  assign x     = crd[0];
  assign y     = crd[1];
endmodule

// ----- sv/twsc_angle.sv -----
`timescale 1ns / 1ps
module twsc_angle (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               vld_i,
  input  logic signed [twsc_pkg::CRD_W-1:0]  x,
  input  logic signed [twsc_pkg::CRD_W-1:0]  y,
  input  logic [twsc_pkg::STR_W-1:0]         strength,
  output logic                               vld_o,
  output logic signed [twsc_pkg::XW-1:0]     xf,
  output logic signed [twsc_pkg::XW-1:0]     yf,
  output logic signed [twsc_pkg::TW-1:0]     t
);
  import twsc_pkg::*;

  localparam int NS   = RT_W + 10;
  localparam int NL   = NS + 1;
  localparam int M_W  = RT_W + STR_W;
  localparam int PM_W = 2 * M_W;
  localparam int K    = M_W + 2;
  localparam int QW   = M_W - 2;
  localparam int TS   = 29 - FRAC_BITS;
  localparam int NMOD = 5;
  localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << K) + 64'd4) / 64'd5);
  localparam logic [TS-1:0]  T1 = TS'((1 << TS) / 5);
  localparam logic [TS-1:0]  T2 = TS'((2 << TS) / 5);
  localparam logic [TS-1:0]  T3 = TS'((3 << TS) / 5);
  localparam logic [TS-1:0]  T4 = TS'((4 << TS) / 5);
  localparam logic [TU_W-1:0] TWO_PI_U = TU_W'(ANG_TWO_PI);
  localparam logic [TU_W-1:0] PI_U     = TU_W'(ANG_PI);

  logic [NL-1:0]             vld;
  logic signed [CRD_W-1:0]   xd [NS];
  logic signed [CRD_W-1:0]   yd [NS];
  logic signed [SQ_W-1:0]    xx;
  logic signed [SQ_W-1:0]    yy;
  logic [SQ_W-1:0]           srem [RT_W+1];
  logic [RT_W-1:0]           root [RT_W+1];
  logic [M_W-1:0]            m;
  logic [M_W-1:0]            m2;
  logic [PM_W-1:0]           pm;
  logic [QW-1:0]             q;
  logic [2:0]                r5;
  logic [TS-1:0]             frac;
  logic [TU_W-1:0]           tm [NMOD+1];
  logic signed [TW-1:0]      tw;
  logic signed [TW-1:0]      t_next;
  logic                      flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NL-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xd[0] <= x;
      yd[0] <= y;
      for (int j = 1; j < NS; j++) begin
        xd[j] <= xd[j-1];
        yd[j] <= yd[j-1];
      end
    end
  end

  assign xx = SQ_W'(x) * SQ_W'(x);
  assign yy = SQ_W'(y) * SQ_W'(y);

  always_ff @(posedge clk) begin
    if (en) begin
      srem[0] <= SQ_W'(xx) + SQ_W'(yy);
    end
  end

  assign root[0] = '0;

  for (genvar s = 0; s < RT_W; s++) begin : g_sqrt
    localparam int B = RT_W - 1 - s;
    logic [SQ_W:0] trial;
    logic          ge;

    assign trial = ((SQ_W+1)'(root[s]) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));
    assign ge    = {1'b0, srem[s]} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        srem[s+1] <= ge ? SQ_W'({1'b0, srem[s]} - trial) : srem[s];
        root[s+1] <= ge ? (root[s] | (RT_W'(1) << B)) : root[s];
      end
    end
  end

  assign q  = QW'(pm >> K);
  assign r5 = 3'(m2 - ((M_W'(q) << 2) + M_W'(q)));

  always_comb begin
    unique case (r5)
      3'd1:    frac = T1;
      3'd2:    frac = T2;
      3'd3:    frac = T3;
      3'd4:    frac = T4;
      default: frac = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m     <= M_W'(root[RT_W]) * M_W'(strength);
      pm    <= PM_W'(m) * PM_W'(RECIP);
      m2    <= m;
      tm[0] <= (TU_W'(q) << TS) + TU_W'(frac);
    end
  end

  for (genvar j = 0; j < NMOD; j++) begin : g_mod
    localparam logic [TU_W-1:0] SUB = TWO_PI_U << (NMOD - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        tm[j+1] <= (tm[j] >= SUB) ? tm[j] - SUB : tm[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tw <= (tm[NMOD] > PI_U) ? TW'(tm[NMOD]) - ANG_TWO_PI : TW'(tm[NMOD]);
    end
  end

  always_comb begin
    priority if (tw > ANG_HALF_PI) begin
      t_next = tw - ANG_PI;
      flip   = 1'b1;
    end else if (tw < -ANG_HALF_PI) begin
      t_next = tw + ANG_PI;
      flip   = 1'b1;
    end else begin
      t_next = tw;
      flip   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t  <= t_next;
      xf <= flip ? -XW'(xd[NS-1]) : XW'(xd[NS-1]);
      yf <= flip ? -XW'(yd[NS-1]) : XW'(yd[NS-1]);
    end
  end

  assign vld_o = vld[NL-1];
endmodule

// ----- sv/twsc_cordic.sv -----
`timescale 1ns / 1ps
module twsc_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic signed [twsc_pkg::XW-1:0]    xf,
  input  logic signed [twsc_pkg::XW-1:0]    yf,
  input  logic signed [twsc_pkg::TW-1:0]    t,
  output logic                              vld_o,
  output logic signed [twsc_pkg::CW-1:0]    u,
  output logic signed [twsc_pkg::CW-1:0]    v
);
  import twsc_pkg::*;

  localparam int NL = CORDIC_ITERS + 1;
  localparam int PW = XW + 32;

  logic [NL-1:0]          vld;
  logic signed [PW-1:0]   pu;
  logic signed [PW-1:0]   pv;
  logic signed [CW-1:0]   uu [CORDIC_ITERS+1];
  logic signed [CW-1:0]   vv [CORDIC_ITERS+1];
  logic signed [TW-1:0]   tt [CORDIC_ITERS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NL-2:0], vld_i};
    end
  end

  assign pu = PW'(xf) * PW'(CORDIC_KINV);
  assign pv = PW'(yf) * PW'(CORDIC_KINV);

  always_ff @(posedge clk) begin
    if (en) begin
      uu[0] <= CW'(pu >>> 30);
      vv[0] <= CW'(pv >>> 30);
      tt[0] <= t;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic signed [TW-1:0] ATN = TW'(ATAN_Q30[i]);
    logic signed [CW-1:0] du;
    logic signed [CW-1:0] dv;

    assign du = vv[i] >>> i;
    assign dv = uu[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!tt[i][TW-1]) begin
          uu[i+1] <= uu[i] - du;
          vv[i+1] <= vv[i] + dv;
          tt[i+1] <= tt[i] - ATN;
        end else begin
          uu[i+1] <= uu[i] + du;
          vv[i+1] <= vv[i] - dv;
          tt[i+1] <= tt[i] + ATN;
        end
      end
    end
  end

  assign vld_o = vld[NL-1];
  assign u     = uu[CORDIC_ITERS];
  assign v     = vv[CORDIC_ITERS];
endmodule

// ----- sv/twsc_pixel.sv -----
`timescale 1ns / 1ps
module twsc_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              vld_i,
  input  logic signed [twsc_pkg::CW-1:0]    u,
  input  logic signed [twsc_pkg::CW-1:0]    v,
  input  logic [twsc_pkg::DIM_W-1:0]        rows,
  input  logic [twsc_pkg::DIM_W-1:0]        cols,
  output logic                              vld_o,
  output logic [twsc_pkg::POS_W-1:0]        src_row,
  output logic [twsc_pkg::POS_W-1:0]        src_col
);
  import twsc_pkg::*;

  localparam int PR_W = CW + DIM_W;
  localparam int QP_W = PR_W - FRAC_BITS;
  localparam logic signed [CW:0] HALF = (CW+1)'(1 << (FRAC_BITS - 1));

  logic [1:0]              vld;
  logic signed [CW-1:0]    crd [2];
  logic [DIM_W-1:0]        dim [2];
  logic [POS_W-1:0]        pix [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], vld_i};
    end
  end

  assign crd[0] = v;
  assign crd[1] = u;
  assign dim[0] = rows;
  assign dim[1] = cols;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [CW:0]  p;
    logic                pos;
    logic [PR_W-1:0]     prod;
    logic [QP_W-1:0]     qp;

    assign p  = (CW+1)'(crd[l]) + HALF;
    assign qp = QP_W'(prod >> FRAC_BITS);

    always_ff @(posedge clk) begin
      if (en) begin
        pos    <= (p > 0);
        prod   <= PR_W'(p[CW-1:0]) * PR_W'(dim[l]);
        pix[l] <= !pos ? '0 :
                  (qp >= QP_W'(dim[l])) ? POS_W'(dim[l] - 1'b1) : POS_W'(qp);
      end
    end
  end

  assign vld_o   = vld[1];
  assign src_row = pix[0];
  assign src_col = pix[1];
endmodule

// ----- sv/twirl_warp_source_coordinate_core.sv -----
`timescale 1ns / 1ps
// Pipeline: 29 divide, 29 radius/angle, 29 CORDIC and 2 pixel scaling
//   stages between input item accept and result valid.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output register.
// Reset: synchronous, clears all valid bits and restores the registers
//   to 512 rows, 512 columns and strength 80.
module twirl_warp_source_coordinate_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr,
  input  logic [twsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twsc_pkg::CFG_W-1:0]      cfg_data,
  twsc_in_if.sink                         pix_in,
  twsc_out_if.source                      pix_out
);
  import twsc_pkg::*;

  logic [DIM_W-1:0]          image_rows;
  logic [DIM_W-1:0]          image_cols;
  logic [STR_W-1:0]          twirl_strength;
  logic [DIM_W-1:0]          rows_eff;
  logic [DIM_W-1:0]          cols_eff;
  logic                      en;
  logic                      n_vld;
  logic signed [CRD_W-1:0]   x;
  logic signed [CRD_W-1:0]   y;
  logic                      a_vld;
  logic signed [XW-1:0]      xf;
  logic signed [XW-1:0]      yf;
  logic signed [TW-1:0]      t;
  logic                      c_vld;
  logic signed [CW-1:0]      u;
  logic signed [CW-1:0]      v;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows     <= ROWS_RST;
      image_cols     <= COLS_RST;
      twirl_strength <= STRENGTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ROWS:     image_rows     <= cfg_data;
        REG_COLS:     image_cols     <= cfg_data;
        REG_STRENGTH: twirl_strength <= cfg_data[STR_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    priority if (image_rows == '0) rows_eff = DIM_W'(1);
    else if (image_rows > DIM_W'(MAX_DIM)) rows_eff = DIM_W'(MAX_DIM);
    else rows_eff = image_rows;
    priority if (image_cols == '0) cols_eff = DIM_W'(1);
    else if (image_cols > DIM_W'(MAX_DIM)) cols_eff = DIM_W'(MAX_DIM);
    else cols_eff = image_cols;
  end

  // advance everything unless the output item is stuck
  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  twsc_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vld_i (pix_in.valid),
    .row   (pix_in.out_row),
    .col   (pix_in.out_col),
    .rows  (rows_eff),
    .cols  (cols_eff),
    .vld_o (n_vld),
    .x     (x),
    .y     (y)
  );

  twsc_angle u_angle (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_i    (n_vld),
    .x        (x),
    .y        (y),
    .strength (twirl_strength),
    .vld_o    (a_vld),
    .xf       (xf),
    .yf       (yf),
    .t        (t)
  );

  twsc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vld_i (a_vld),
    .xf    (xf),
    .yf    (yf),
    .t     (t),
    .vld_o (c_vld),
    .u     (u),
    .v     (v)
  );

  twsc_pixel u_pixel (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_i   (c_vld),
    .u       (u),
    .v       (v),
    .rows    (rows_eff),
    .cols    (cols_eff),
    .vld_o   (pix_out.valid),
    .src_row (pix_out.src_row),
    .src_col (pix_out.src_col)
  );

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !pix_out.valid)
    else $error("output valid after reset");

  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    rows_eff != '0 && rows_eff <= DIM_W'(MAX_DIM))
    else $error("effective row count out of range");

  a_cols_range: assert property (@(posedge clk) disable iff (rst)
    cols_eff != '0 && cols_eff <= DIM_W'(MAX_DIM))
    else $error("effective column count out of range");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.ready) |=> (c_vld == $past(c_vld)))
    else $error("pipeline moved during stall");
endmodule
